// ===== rtl/bdec_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII converter.
package bdec_pkg;

   localparam int NUMBER_BITS_DEFAULT = 32;
   localparam int MAX_DIGITS_DEFAULT  = 10;

   localparam int DIGIT_W = 4;
   localparam int CHAR_W  = 6;

   localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 6'd48;
   localparam logic [DIGIT_W-1:0] DABBLE_MIN  = 4'd5;
   localparam logic [DIGIT_W-1:0] DABBLE_ADD  = 4'd3;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_DABBLE,
      CELL_SHIFT
   } cell_op_type;

endpackage

// ===== rtl/bdec_cell.sv =====
// One BCD digit cell of the conversion chain: clear, hold, add-3 correct and shift, or pass digits up.
module bdec_cell (
   input  logic                          clock,
   input  bdec_pkg::cell_op_type         op,
   input  logic                          bit_in,
   output logic                          bit_out,
   input  logic [bdec_pkg::DIGIT_W-1:0]  digit_in,
   output logic [bdec_pkg::DIGIT_W-1:0]  digit_out
);
   import bdec_pkg::*;

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in_w;
   logic [DIGIT_W-1:0] corrected_w;

   // correct before shift so the shifted digit stays below ten
   assign corrected_w = (digit_ff >= DABBLE_MIN) ? digit_ff + DABBLE_ADD : digit_ff;
   assign bit_out     = corrected_w[DIGIT_W-1];
   assign digit_out   = digit_ff;

   always_comb begin
      case (op)
         CELL_HOLD:   digit_in_w = digit_ff;
         CELL_CLEAR:  digit_in_w = '0;
         CELL_DABBLE: digit_in_w = {corrected_w[DIGIT_W-2:0], bit_in};
         CELL_SHIFT:  digit_in_w = digit_in;
         default:     digit_in_w = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_w;
   end

endmodule

// ===== rtl/binary_to_decimal_ascii_top.sv =====
// Top level: binary number in, decimal ASCII digits out, most significant first.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid, req_ready, req_number        | in
//  rsp     | rsp_valid, rsp_ready, rsp_char_code,    | out
//          | rsp_last                                |
//
// After acceptance a number goes through NUMBER_BITS double-dabble steps through the
// digit cell chain, then through each digit cell in turn, either dropping a leading
// zero or presenting a character.
// Reset is synchronous and clears the control state; the digit cells need none.
// A stalled rsp channel holds the chain; a new number is taken once the last
// character sits in the output register.
module binary_to_decimal_ascii_top #(
   parameter int NUMBER_BITS = bdec_pkg::NUMBER_BITS_DEFAULT,
   parameter int MAX_DIGITS  = bdec_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [NUMBER_BITS-1:0]        req_number,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bdec_pkg::CHAR_W-1:0]   rsp_char_code,
   output logic                          rsp_last
);
   import bdec_pkg::*;

   localparam int BIT_CNT_W = $clog2(NUMBER_BITS);
   localparam int CNT_W     = $clog2(MAX_DIGITS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   state_type              state_ff;
   logic [NUMBER_BITS-1:0] num_ff;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff;
   logic [CNT_W-1:0]       remain_ff;
   logic                   ovf_ff;
   logic                   rsp_valid_ff;
   logic [CHAR_W-1:0]      rsp_char_code_ff;
   logic                   rsp_last_ff;

   cell_op_type            cell_op;
   logic                   carry_w [0:MAX_DIGITS];
   logic [DIGIT_W-1:0]     digit_w [0:MAX_DIGITS-1];
   logic [DIGIT_W-1:0]     link_w  [0:MAX_DIGITS-1];
   logic [DIGIT_W-1:0]     top_digit;
   logic                   accept_w;
   logic                   skip_w;
   logic                   emit_w;

   assign accept_w  = req_valid && req_ready;
   assign top_digit = digit_w[MAX_DIGITS-1];
   assign carry_w[0] = num_ff[NUMBER_BITS-1];

   // drop a leading zero unless it is the only digit left or high digits were lost
   assign skip_w = !ovf_ff && (top_digit == '0) && (remain_ff > CNT_W'(1));
   assign emit_w = !rsp_valid_ff || rsp_ready;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_DIGITS; gi++) begin : g_cell
         if (gi == 0) begin : g_first
            assign link_w[gi] = '0;
         end else begin : g_rest
            assign link_w[gi] = digit_w[gi-1];
         end
         bdec_cell u_cell (
            .clock     (clock),
            .op        (cell_op),
            .bit_in    (carry_w[gi]),
            .bit_out   (carry_w[gi+1]),
            .digit_in  (link_w[gi]),
            .digit_out (digit_w[gi])
         );
      end
   endgenerate

   always_comb begin
      case (state_ff)
         ST_IDLE:    cell_op = accept_w ? CELL_CLEAR : CELL_HOLD;
         ST_CONVERT: cell_op = CELL_DABBLE;
         ST_SKIP:    cell_op = skip_w ? CELL_SHIFT : CELL_HOLD;
         ST_EMIT:    cell_op = emit_w ? CELL_SHIFT : CELL_HOLD;
         default:    cell_op = CELL_HOLD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         remain_ff    <= '0;
         bit_cnt_ff   <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         // while emitting, the output register is reloaded below instead
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept_w) begin
                  num_ff     <= req_number;
                  bit_cnt_ff <= BIT_CNT_W'(NUMBER_BITS - 1);
                  remain_ff  <= CNT_W'(MAX_DIGITS);
                  ovf_ff     <= 1'b0;
                  state_ff   <= ST_CONVERT;
               end
            end
            ST_CONVERT: begin
               num_ff <= {num_ff[NUMBER_BITS-2:0], 1'b0};
               ovf_ff <= ovf_ff | carry_w[MAX_DIGITS];
               bit_cnt_ff <= bit_cnt_ff - BIT_CNT_W'(1);
               if (bit_cnt_ff == '0) begin
                  state_ff <= ST_SKIP;
               end
            end
            ST_SKIP: begin
               if (skip_w) begin
                  remain_ff <= remain_ff - CNT_W'(1);
               end else begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (emit_w) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_char_code_ff <= ASCII_ZERO + CHAR_W'(top_digit);
                  rsp_last_ff      <= (remain_ff == CNT_W'(1));
                  remain_ff        <= remain_ff - CNT_W'(1);
                  if (remain_ff == CNT_W'(1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_code_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ===== dv/binary_to_decimal_ascii_top_test.sv =====
// Testbench for the binary to decimal ASCII converter: directed and random traffic, predicted digits.
`timescale 1ns / 100ps

module binary_to_decimal_ascii_top_test;

   localparam int NUMBER_BITS  = bdec_pkg::NUMBER_BITS_DEFAULT;
   localparam int MAX_DIGITS   = bdec_pkg::MAX_DIGITS_DEFAULT;
   localparam int DIGIT_W      = bdec_pkg::DIGIT_W;
   localparam int DECIMAL_BASE = 10;
   localparam int MAX_WAIT     = 5;
   localparam int RANDOM_ITEMS = 300;
   localparam int HOLD_AFTER   = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 60;
   localparam int STALL_LIMIT  = 2000;

   typedef struct {
      logic [NUMBER_BITS-1:0] number;
      int                     gap;
      bit                     drain;
   } number_item_type;

   typedef struct {
      logic [bdec_pkg::CHAR_W-1:0] char_code;
      logic                        last;
   } digit_char_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [NUMBER_BITS-1:0]      req_number = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [bdec_pkg::CHAR_W-1:0] rsp_char_code;
   logic                        rsp_last;

   number_item_type numbers_to_send[$];
   digit_char_type  digit_chars_due[$];

   number_item_type current_item;
   bit           item_loaded = 1'b0;
   int           gap_left = 0;
   bit           send_calm = 1'b0;
   bit           req_taken = 1'b0;
   bit           rsp_taken = 1'b0;
   int           rsp_wait = 0;
   bit           rsp_calm = 1'b0;
   logic         rsp_hold = 1'b0;
   int           hold_count = 0;
   bit           hold_done = 1'b0;
   int           numbers_taken = 0;
   int           idle_cycles = 0;
   int           mismatch_count = 0;

   binary_to_decimal_ascii_top #(
      .NUMBER_BITS (NUMBER_BITS),
      .MAX_DIGITS  (MAX_DIGITS)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_number    (req_number),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   always #10 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Push the characters of one number, most significant digit first.
   task automatic predict_digits(input logic [NUMBER_BITS-1:0] value);
      logic [DIGIT_W-1:0]           digits [MAX_DIGITS];
      logic [NUMBER_BITS-1:0]       rest;
      int                           count;
      digit_char_type               ch;
      rest  = value;
      count = 0;
      do begin
         digits[count] = DIGIT_W'(rest % DECIMAL_BASE);
         rest          = rest / DECIMAL_BASE;
         count++;
      end while (rest != 0 && count < MAX_DIGITS);
      for (int k = count; k > 0; k--) begin
         ch.char_code = bdec_pkg::ASCII_ZERO + {2'b00, digits[k-1]};
         ch.last      = (k == 1);
         digit_chars_due.push_back(ch);
      end
   endtask

   task automatic add_number(input logic [NUMBER_BITS-1:0] value, input bit drain);
      number_item_type item;
      item.number = value;
      item.gap    = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
      item.drain  = drain;
      numbers_to_send.push_back(item);
   endtask

   // Sender: offer at the falling edge, hold until the transaction completes.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (!item_loaded && numbers_to_send.size() > 0) begin
            current_item = numbers_to_send.pop_front();
            item_loaded  = 1'b1;
            gap_left     = current_item.gap;
         end
         if (item_loaded && gap_left == 0 &&
             !(current_item.drain && digit_chars_due.size() != 0)) begin
            req_valid   <= 1'b1;
            req_number  <= current_item.number;
            item_loaded  = 1'b0;
         end else begin
            req_valid <= 1'b0;
            if (item_loaded && gap_left > 0)
               gap_left--;
         end
      end
   end

   // Receiver: random stall after each transaction, plus the long hold-off.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            if ($urandom_range(0, 39) == 0)
               rsp_calm = !rsp_calm;
            rsp_wait = rsp_calm ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (rsp_hold || rsp_wait > 0) begin
            rsp_ready <= 1'b0;
            if (rsp_wait > 0)
               rsp_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Long hold-off on the result side so the block backs up into its input.
   always @(posedge clock) begin
      if (!reset && !hold_done && numbers_taken >= HOLD_AFTER) begin
         if (hold_count < HOLD_CYCLES) begin
            rsp_hold   <= 1'b1;
            hold_count  = hold_count + 1;
         end else begin
            rsp_hold  <= 1'b0;
            hold_done  = 1'b1;
         end
      end
   end

   // Monitor: predict on input transactions, check output transactions.
   always @(posedge clock) begin
      digit_char_type want;
      req_taken <= !reset && req_valid && req_ready;
      rsp_taken <= !reset && rsp_valid && rsp_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_digits(req_number);
            numbers_taken <= numbers_taken + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (digit_chars_due.size() == 0) begin
               report_mismatch($sformatf("unexpected char 0x%0h last %0b",
                                         rsp_char_code, rsp_last));
            end else begin
               want = digit_chars_due.pop_front();
               if (rsp_char_code !== want.char_code)
                  report_mismatch($sformatf("char_code 0x%0h, want 0x%0h",
                                            rsp_char_code, want.char_code));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b, want %0b", rsp_last, want.last));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("TIMEOUT: no transaction for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      logic [NUMBER_BITS-1:0] value;
      // Directed: zero, single digits, powers of ten and their neighbors, the extremes.
      add_number(32'd0, 1'b0);
      add_number(32'd1, 1'b0);
      add_number(32'd9, 1'b0);
      add_number(32'd10, 1'b0);
      add_number(32'd99, 1'b0);
      add_number(32'd100, 1'b0);
      add_number(32'd1000000000, 1'b0);
      add_number(32'd999999999, 1'b0);
      add_number(32'd1000000001, 1'b0);
      add_number(32'd1234567890, 1'b0);
      add_number(32'hFFFF_FFFF, 1'b0);
      add_number(32'hFFFF_FFFE, 1'b0);
      add_number(32'h8000_0000, 1'b0);
      add_number(32'h7FFF_FFFF, 1'b0);
      add_number(32'h5555_5555, 1'b0);
      add_number(32'hAAAA_AAAA, 1'b0);
      add_number(32'd65535, 1'b0);
      add_number(32'd65536, 1'b0);
      add_number(32'd4000000000, 1'b0);
      add_number(32'd0, 1'b0);
      add_number(32'd42, 1'b1);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 20 == 0)
            send_calm = ($urandom_range(0, 2) == 0);
         case ($urandom_range(0, 3))
            0: value = $urandom;
            1: value = $urandom >> $urandom_range(0, 31);
            2: value = $urandom_range(0, 20);
            default: value = $urandom % 32'd1000000000 + ($urandom_range(0, 1) ?
                                                          32'd0 : 32'd1000000000);
         endcase
         add_number(value, $urandom_range(0, 29) == 0);
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (numbers_to_send.size() != 0 || item_loaded || req_valid ||
             digit_chars_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
